// ===== design/rmth_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmth_pkg
// Shared widths, defaults and cell operation codes for the running median core.
// ----------------------------------------------------------------------------
package rmth_pkg;

    localparam int CAPACITY_DEF   = 1024;
    localparam int VALUE_BITS_DEF = 16;

    // Widths of the beat payloads on the two channels.
    localparam int IN_W  = 16;
    localparam int OUT_W = 16;

    typedef logic [1:0] t_chain_op;

    localparam t_chain_op OP_HOLD    = 2'd0;
    localparam t_chain_op OP_INSERT  = 2'd1;
    localparam t_chain_op OP_INS_POP = 2'd2;
    localparam t_chain_op OP_PUSH    = 2'd3;

endpackage
`default_nettype wire

// ===== design/rmth_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmth_if
// Valid/ready channels carrying samples in and median results out.
// ----------------------------------------------------------------------------
interface rmth_in_if;
    logic                      valid;
    logic                      ready;
    logic [rmth_pkg::IN_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface rmth_out_if;
    logic                       valid;
    logic                       ready;
    logic [rmth_pkg::OUT_W-1:0] median;
    logic                       full_res;

    modport source (output valid, output median, output full_res, input ready);
    modport sink   (input valid, input median, input full_res, output ready);
endinterface
`default_nettype wire

// ===== design/rmth_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmth_cell
// One slot of a sorted chain: holds a value and picks its next value from
// itself, its neighbours or the broadcast sample.
// ----------------------------------------------------------------------------
module rmth_cell #(
    parameter int W       = rmth_pkg::VALUE_BITS_DEF,
    parameter bit DESCEND = 1'b1
) (
    input  wire                 i_clk,
    input  rmth_pkg::t_chain_op i_op,
    input  wire                 i_occ,
    input  wire  [W-1:0]        i_sample,
    input  wire  [W-1:0]        i_left,
    input  wire                 i_left_keep,
    input  wire  [W-1:0]        i_right,
    input  wire                 i_right_keep,
    output logic [W-1:0]        o_val,
    output logic                o_keep,
    output logic [W-1:0]        o_next
);

    logic [W-1:0] r_val;
    logic [W-1:0] n_val;

    // A cell keeps its place when it is occupied and already ordered ahead of
    // the sample.
    assign o_keep = i_occ && (DESCEND ? (r_val >= i_sample) : (r_val <= i_sample));

    always_comb begin
        unique case (i_op)
            rmth_pkg::OP_INSERT: begin
                if (o_keep) begin
                    n_val = r_val;
                end else if (i_left_keep) begin
                    n_val = i_sample;
                end else begin
                    n_val = i_left;
                end
            end
            // Insert and drop the head at once: cells ahead of the sample move one place
            // towards the head, the sample fills the gap behind them and the rest hold.
            rmth_pkg::OP_INS_POP: begin
                if (i_right_keep) begin
                    n_val = i_right;
                end else if (o_keep) begin
                    n_val = i_sample;
                end else begin
                    n_val = r_val;
                end
            end
            rmth_pkg::OP_PUSH: n_val = i_left;
            default:           n_val = r_val;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val  = r_val;
    assign o_next = n_val;

endmodule
`default_nettype wire

// ===== design/rmth_chain.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmth_chain
// A row of cells kept sorted with its extreme value at the head, cell zero.
// ----------------------------------------------------------------------------
module rmth_chain #(
    parameter int W       = rmth_pkg::VALUE_BITS_DEF,
    parameter int DEPTH   = (rmth_pkg::CAPACITY_DEF + 1) / 2,
    parameter bit DESCEND = 1'b1,
    localparam int SW     = $clog2(DEPTH + 1)
) (
    input  wire                 i_clk,
    input  rmth_pkg::t_chain_op i_op,
    input  wire  [SW-1:0]       i_size,
    input  wire  [W-1:0]        i_sample,
    input  wire  [W-1:0]        i_push,
    output logic [W-1:0]        o_head,
    output logic [W-1:0]        o_head_next,
    output logic                o_head_keep
);

    logic [W-1:0] val  [DEPTH];
    logic         keep [DEPTH];

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        localparam logic [SW-1:0] IDX = SW'(i);

        logic         occ;
        logic [W-1:0] left;
        logic         left_keep;
        logic [W-1:0] right;
        logic         right_keep;

        assign occ = IDX < i_size;

        // The head's left neighbour is the value pushed in from the other
        // chain; for an insertion it always counts as kept.
        if (i == 0) begin : g_head
            assign left      = i_push;
            assign left_keep = 1'b1;
        end else begin : g_body
            assign left      = val[i-1];
            assign left_keep = keep[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            assign right      = val[i];
            assign right_keep = 1'b0;
        end else begin : g_inner
            assign right      = val[i+1];
            assign right_keep = keep[i+1];
        end

        if (i == 0) begin : g_next
            rmth_cell #(
                .W       (W),
                .DESCEND (DESCEND)
            ) u_cell (
                .i_clk        (i_clk),
                .i_op         (i_op),
                .i_occ        (occ),
                .i_sample     (i_sample),
                .i_left       (left),
                .i_left_keep  (left_keep),
                .i_right      (right),
                .i_right_keep (right_keep),
                .o_val        (val[i]),
                .o_keep       (keep[i]),
                .o_next       (o_head_next)
            );
        end else begin : g_plain
            rmth_cell #(
                .W       (W),
                .DESCEND (DESCEND)
            ) u_cell (
                .i_clk        (i_clk),
                .i_op         (i_op),
                .i_occ        (occ),
                .i_sample     (i_sample),
                .i_left       (left),
                .i_left_keep  (left_keep),
                .i_right      (right),
                .i_right_keep (right_keep),
                .o_val        (val[i]),
                .o_keep       (keep[i]),
                .o_next       ()
            );
        end
    end

    assign o_head      = val[0];
    assign o_head_keep = keep[0];

endmodule
`default_nettype wire

// ===== design/running_median_two_heaps_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Latency: the result beat for a sample is valid in the cycle after the sample
// beat is accepted. Throughput: one sample per cycle unless the output stalls;
// every cell of both rows compares with the sample and moves that same cycle.
// Reset clears the fill counts, the held median and the output valid; the cell
// contents are not reset and only occupied cells are ever looked at.
// ----------------------------------------------------------------------------
// running_median_two_heaps_core
// Streaming median over a lower half kept descending and an upper half kept
// ascending in two rows of cells, rebalanced so sizes differ by at most one.
// ----------------------------------------------------------------------------
module running_median_two_heaps_core #(
    parameter int CAPACITY   = rmth_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS = rmth_pkg::VALUE_BITS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    rmth_in_if.sink     i_in,
    rmth_out_if.source  o_out
);

    localparam int DEPTH = (CAPACITY + 1) / 2;
    localparam int SW    = $clog2(DEPTH + 1);
    localparam int TW    = SW + 1;
    localparam int OW    = rmth_pkg::OUT_W;
    localparam int VB    = VALUE_BITS;
    localparam logic [TW-1:0] CAP_FULL = TW'(CAPACITY);

    logic [SW-1:0] r_lo_size, n_lo_size;
    logic [SW-1:0] r_up_size, n_up_size;
    logic [VB-1:0] r_last;
    logic          r_out_valid;
    logic [OW-1:0] r_out_median;
    logic          r_out_full;

    logic [VB-1:0]       sample;
    logic                accept;
    logic                full;
    logic                go_up;
    logic [TW-1:0]       total;
    rmth_pkg::t_chain_op lo_op, up_op;
    logic [VB-1:0]       lo_head, lo_head_next, up_head, up_head_next;
    logic                lo_keep0, up_keep0;
    logic [VB-1:0]       lo_pop, up_pop;
    logic [VB:0]         pair_sum;
    logic [VB-1:0]       median;

    assign sample = VB'(i_in.value);
    assign accept = i_in.valid && i_in.ready;
    assign total  = TW'(r_lo_size) + TW'(r_up_size);
    assign full   = total >= CAP_FULL;
    assign go_up  = (r_lo_size != '0) && (sample > lo_head);

    // The value leaving a row on rebalance is its head after the insertion.
    assign lo_pop = lo_keep0 ? lo_head : sample;
    assign up_pop = up_keep0 ? up_head : sample;

    always_comb begin
        lo_op     = rmth_pkg::OP_HOLD;
        up_op     = rmth_pkg::OP_HOLD;
        n_lo_size = r_lo_size;
        n_up_size = r_up_size;
        if (accept && !full) begin
            if (go_up) begin
                if (r_up_size == r_lo_size + SW'(1)) begin
                    up_op     = rmth_pkg::OP_INS_POP;
                    lo_op     = rmth_pkg::OP_PUSH;
                    n_lo_size = r_lo_size + SW'(1);
                end else begin
                    up_op     = rmth_pkg::OP_INSERT;
                    n_up_size = r_up_size + SW'(1);
                end
            end else begin
                if (r_lo_size == r_up_size + SW'(1)) begin
                    lo_op     = rmth_pkg::OP_INS_POP;
                    up_op     = rmth_pkg::OP_PUSH;
                    n_up_size = r_up_size + SW'(1);
                end else begin
                    lo_op     = rmth_pkg::OP_INSERT;
                    n_lo_size = r_lo_size + SW'(1);
                end
            end
        end
    end

    rmth_chain #(
        .W       (VB),
        .DEPTH   (DEPTH),
        .DESCEND (1'b1)
    ) u_lower (
        .i_clk       (i_clk),
        .i_op        (lo_op),
        .i_size      (r_lo_size),
        .i_sample    (sample),
        .i_push      (up_pop),
        .o_head      (lo_head),
        .o_head_next (lo_head_next),
        .o_head_keep (lo_keep0)
    );

    rmth_chain #(
        .W       (VB),
        .DEPTH   (DEPTH),
        .DESCEND (1'b0)
    ) u_upper (
        .i_clk       (i_clk),
        .i_op        (up_op),
        .i_size      (r_up_size),
        .i_sample    (sample),
        .i_push      (lo_pop),
        .o_head      (up_head),
        .o_head_next (up_head_next),
        .o_head_keep (up_keep0)
    );

    assign pair_sum = {1'b0, lo_head_next} + {1'b0, up_head_next};

    always_comb begin
        if (n_lo_size > n_up_size) begin
            median = lo_head_next;
        end else if (n_up_size > n_lo_size) begin
            median = up_head_next;
        end else begin
            median = pair_sum[VB:1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo_size   <= '0;
            r_up_size   <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_lo_size <= n_lo_size;
            r_up_size <= n_up_size;
            if (accept) begin
                r_out_valid <= 1'b1;
                if (!full) begin
                    r_last <= median;
                end
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload; a dropped sample repeats the last median.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_median <= full ? OW'(r_last) : OW'(median);
            r_out_full   <= full;
        end
    end

    assign i_in.ready     = !r_out_valid || o_out.ready;
    assign o_out.valid    = r_out_valid;
    assign o_out.median   = r_out_median;
    assign o_out.full_res = r_out_full;

endmodule
`default_nettype wire
